FILE: rtl/monochrome_framebuffer_page_flush_defines.svh
// assertion macros used by the framebuffer flush rtl
`ifndef MONOCHROME_FRAMEBUFFER_PAGE_FLUSH_DEFINES_SVH
`define MONOCHROME_FRAMEBUFFER_PAGE_FLUSH_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MFPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// antecedent implies consequent in the next cycle
`define MFPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define MFPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MFPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mfpf_pkg.sv
// shared types and constants of the framebuffer flush block
package mfpf_pkg;

    // command codes
    localparam logic [2:0] CMD_DRAW  = 3'd0;
    localparam logic [2:0] CMD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_PULL  = 3'd4;
    localparam logic [2:0] CMD_POWER = 3'd5;

    // result status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_EMPTY  = 2'd1;
    localparam logic [1:0] STS_REJECT = 2'd2;
    localparam logic [1:0] STS_BUSY   = 2'd3;

    // flush sequence phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PAGE  = 3'd1;
    localparam logic [2:0] PH_COL_A = 3'd2;
    localparam logic [2:0] PH_COL_B = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_POWER = 3'd5;

    // pixel walk operations
    localparam logic [1:0] OP_FILL = 2'd0;
    localparam logic [1:0] OP_FLIP = 2'd1;
    localparam logic [1:0] OP_DRAW = 2'd2;

    // display words
    localparam logic [7:0] WORD_PAGE    = 8'hB0;
    localparam logic [7:0] COL_OFFSET   = 8'h02;
    localparam logic [7:0] WORD_COL_HI  = 8'h10;
    localparam logic [3:0] CARRY_LIMIT  = 4'hE;
    localparam logic [7:0] WORD_DISP_ON = 8'hAF;
    localparam logic [7:0] WORD_DISP_OFF = 8'hAE;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic init_wr;
        logic walk_rd;
        logic walk_wr;
        logic fetch_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic walk_go;
        logic fetch_need;
        logic walk_last;
    } dp_sts_t;

endpackage

FILE: rtl/mfpf_datapath.sv
// pixel store, draw and flush registers, pixel walker and result register
module mfpf_datapath #(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mfpf_pkg::ctrl_cmd_t cmd,
    output mfpf_pkg::dp_sts_t   sts,
    input  logic [2:0]          command,
    input  logic [7:0]          row_first,
    input  logic [7:0]          col_first,
    input  logic [7:0]          row_last,
    input  logic [7:0]          col_last,
    input  logic [7:0]          width,
    input  logic [7:0]          height,
    input  logic [7:0]          pixel_byte,
    input  logic                invert,
    input  logic                toggle,
    input  logic                fill,
    input  logic                power_on,
    output logic [7:0]          word,
    output logic                is_data,
    output logic                last,
    output logic [1:0]          status
);
    import mfpf_pkg::*;

    localparam int PAGES = (ROWS + 7) / 8;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = PW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [9:0] ROW_MAX  = 10'(ROWS - 1);
    localparam logic [9:0] COL_MAX  = 10'(COLUMNS - 1);
    localparam logic [9:0] ROW_LIM  = 10'(ROWS);
    localparam logic [9:0] COL_LIM  = 10'(COLUMNS);
    localparam logic [9:0] PAGE_LIM = 10'(PAGES);
    localparam logic [9:0] PAGE_MAX = 10'(PAGES - 1);

    // pixel store
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_reg;
    logic [AW-1:0] addr;
    logic          we;
    logic [7:0]    wdata;

    // init sweep
    logic [AW-1:0] init_reg;

    // draw state
    logic [8:0] draw_row_reg, draw_row_next;
    logic [8:0] draw_col_reg, draw_col_next;
    logic [7:0] rows_left_reg, rows_left_next;
    logic       d_inv_reg, d_inv_next;
    logic [7:0] d_h_reg, d_h_next;
    logic [7:0] d_cf_reg, d_cf_next;

    // flush state
    logic [2:0]    phase_reg, phase_next;
    logic [PW-1:0] fpage_reg, fpage_next;
    logic [PW-1:0] fpe_reg, fpe_next;
    logic [7:0]    fcb_reg, fcb_next;
    logic [7:0]    fce_reg, fce_next;
    logic [7:0]    fcol_reg, fcol_next;
    logic [7:0]    pword_reg, pword_next;

    // walker
    logic [7:0] wr_reg, wr_next;
    logic [7:0] wc_reg, wc_next;
    logic [7:0] wr_end_reg, wr_end_next;
    logic [7:0] wc_first_reg, wc_first_next;
    logic [7:0] wc_end_reg, wc_end_next;
    logic [2:0] wk_reg, wk_next;
    logic [1:0] wop_reg, wop_next;
    logic       wval_reg, wval_next;
    logic [7:0] wpat_reg, wpat_next;

    // result register
    logic [7:0] word_reg, res_word;
    logic       isd_reg, res_isd;
    logic       last_reg, res_last;
    logic [1:0] st_reg, res_st;

    // temporaries
    logic [8:0] col_addr;
    logic [7:0] lo_word, hi_word;
    logic       carry_first;
    logic [9:0] t_r1, t_c1, c_r1, c_c1, d_s, d_e, d_rem, f_p0, f_p1, c_cl;
    logic       walk_go, fetch_need;
    logic [7:0] bit_mask, wr_byte;
    logic       pix_val, walk_last;

    // column address words for the current flush
    always_comb
    begin
        col_addr    = {1'b0, fcb_reg} + {1'b0, COL_OFFSET};
        lo_word     = {4'h0, col_addr[3:0]};
        hi_word     = WORD_COL_HI + 8'(col_addr >> 4);
        carry_first = (fcb_reg[3:0] >= CARRY_LIMIT);
    end

    // region bounds
    always_comb
    begin
        t_r1  = {2'b0, row_first} + {2'b0, width} - 10'd1;
        t_c1  = {2'b0, col_first} + {2'b0, height} - 10'd1;
        if (t_r1 > ROW_MAX) t_r1 = ROW_MAX;
        if (t_c1 > COL_MAX) t_c1 = COL_MAX;
        c_r1  = {2'b0, row_last};
        c_c1  = {2'b0, col_last};
        if (c_r1 > ROW_MAX) c_r1 = ROW_MAX;
        if (c_c1 > COL_MAX) c_c1 = COL_MAX;
        d_s   = {2'b0, d_cf_reg} + {1'b0, draw_col_reg};
        d_rem = {2'b0, d_h_reg} - {1'b0, draw_col_reg};
        d_e   = (d_rem > 10'd8) ? (d_s + 10'd7) : (d_s + d_rem - 10'd1);
        if (d_e > COL_MAX) d_e = COL_MAX;
        f_p0  = {5'b0, row_first[7:3]};
        f_p1  = {5'b0, row_last[7:3]};
        if (f_p1 > PAGE_MAX) f_p1 = PAGE_MAX;
        c_cl  = {2'b0, col_last};
        if (c_cl > COL_MAX) c_cl = COL_MAX;
    end

    // command decode at transaction accept
    always_comb
    begin
        res_word = 8'h00;
        res_isd  = 1'b0;
        res_last = 1'b0;
        res_st   = STS_OK;
        walk_go    = 1'b0;
        fetch_need = 1'b0;
        draw_row_next  = draw_row_reg;
        draw_col_next  = draw_col_reg;
        rows_left_next = rows_left_reg;
        d_inv_next = d_inv_reg;
        d_h_next   = d_h_reg;
        d_cf_next  = d_cf_reg;
        phase_next = phase_reg;
        fpage_next = fpage_reg;
        fpe_next   = fpe_reg;
        fcb_next   = fcb_reg;
        fce_next   = fce_reg;
        fcol_next  = fcol_reg;
        pword_next = pword_reg;
        wr_next       = wr_reg;
        wc_next       = wc_reg;
        wr_end_next   = wr_end_reg;
        wc_first_next = wc_first_reg;
        wc_end_next   = wc_end_reg;
        wk_next       = wk_reg;
        wop_next      = wop_reg;
        wval_next     = wval_reg;
        wpat_next     = wpat_reg;
        if (command == CMD_PULL)
        begin
            case (phase_reg)
                PH_PAGE:
                begin
                    res_word   = WORD_PAGE | 8'(fpage_reg);
                    phase_next = PH_COL_A;
                end
                PH_COL_A:
                begin
                    res_word   = carry_first ? hi_word : lo_word;
                    phase_next = PH_COL_B;
                end
                PH_COL_B:
                begin
                    res_word = carry_first ? lo_word : hi_word;
                    if (fcb_reg <= fce_reg)
                    begin
                        fcol_next  = fcb_reg;
                        phase_next = PH_DATA;
                    end
                    else if (fpage_reg < fpe_reg)
                    begin
                        fpage_next = fpage_reg + 1'b1;
                        phase_next = PH_PAGE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    res_isd    = 1'b1;
                    fetch_need = 1'b1;
                    if (fcol_reg < fce_reg)
                    begin
                        fcol_next = fcol_reg + 8'd1;
                    end
                    else if (fpage_reg < fpe_reg)
                    begin
                        fpage_next = fpage_reg + 1'b1;
                        phase_next = PH_PAGE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_POWER:
                begin
                    res_word   = pword_reg;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    res_st = STS_EMPTY;
                end
            endcase
            res_last = (res_st == STS_OK) && (phase_next == PH_IDLE);
        end
        else if (command > CMD_POWER)
        begin
            res_st = STS_REJECT;
        end
        else if (phase_reg != PH_IDLE)
        begin
            res_st = STS_BUSY;
        end
        else if (command == CMD_DRAW)
        begin
            rows_left_next = 8'd0;
            if (toggle)
            begin
                walk_go = (width != 8'd0) && (height != 8'd0) &&
                          ({2'b0, row_first} < ROW_LIM) && ({2'b0, col_first} < COL_LIM);
                wr_next       = row_first;
                wc_next       = col_first;
                wc_first_next = col_first;
                wr_end_next   = t_r1[7:0];
                wc_end_next   = t_c1[7:0];
                wk_next       = 3'd0;
                wop_next      = OP_FLIP;
            end
            else if ((width != 8'd0) && (height != 8'd0))
            begin
                draw_row_next  = {1'b0, row_first};
                draw_col_next  = 9'd0;
                rows_left_next = width;
                d_inv_next     = invert;
                d_h_next       = height;
                d_cf_next      = col_first;
            end
        end
        else if (command == CMD_PIXEL)
        begin
            if (rows_left_reg == 8'd0)
            begin
                res_st = STS_EMPTY;
            end
            else
            begin
                walk_go = ({1'b0, draw_row_reg} < ROW_LIM) && (d_s < COL_LIM);
                wr_next       = draw_row_reg[7:0];
                wc_next       = d_s[7:0];
                wc_first_next = d_s[7:0];
                wr_end_next   = draw_row_reg[7:0];
                wc_end_next   = d_e[7:0];
                wk_next       = 3'd0;
                wop_next      = OP_DRAW;
                wval_next     = d_inv_reg;
                wpat_next     = pixel_byte;
                if (draw_col_reg + 9'd8 >= {1'b0, d_h_reg})
                begin
                    draw_col_next  = 9'd0;
                    draw_row_next  = draw_row_reg + 9'd1;
                    rows_left_next = rows_left_reg - 8'd1;
                end
                else
                begin
                    draw_col_next = draw_col_reg + 9'd8;
                end
            end
        end
        else if (command == CMD_CLEAR)
        begin
            if (({2'b0, row_first} >= ROW_LIM) || ({2'b0, col_first} >= COL_LIM))
            begin
                res_st = STS_REJECT;
            end
            else
            begin
                walk_go = (c_r1 >= {2'b0, row_first}) && (c_c1 >= {2'b0, col_first});
                wr_next       = row_first;
                wc_next       = col_first;
                wc_first_next = col_first;
                wr_end_next   = c_r1[7:0];
                wc_end_next   = c_c1[7:0];
                wk_next       = 3'd0;
                wop_next      = OP_FILL;
                wval_next     = fill;
            end
        end
        else if (command == CMD_FLUSH)
        begin
            if ((f_p0 >= PAGE_LIM) || ({2'b0, col_first} >= COL_LIM))
            begin
                res_st = STS_REJECT;
            end
            else if (f_p0 <= f_p1)
            begin
                fpage_next = PW'(f_p0);
                fpe_next   = PW'(f_p1);
                fcb_next   = col_first;
                fce_next   = c_cl[7:0];
                fcol_next  = col_first;
                phase_next = PH_PAGE;
            end
        end
        else
        begin
            pword_next = power_on ? WORD_DISP_ON : WORD_DISP_OFF;
            phase_next = PH_POWER;
        end
    end

    // pixel modify for the walker
    always_comb
    begin
        bit_mask  = 8'h01 << wr_reg[2:0];
        pix_val   = (wop_reg == OP_DRAW) ? (wpat_reg[3'd7 - wk_reg] ^ wval_reg) : wval_reg;
        if (wop_reg == OP_FLIP)
            wr_byte = rd_reg ^ bit_mask;
        else if (pix_val)
            wr_byte = rd_reg | bit_mask;
        else
            wr_byte = rd_reg & ~bit_mask;
        walk_last = (wc_reg == wc_end_reg) && (wr_reg == wr_end_reg);
    end

    // memory port select
    always_comb
    begin
        if (cmd.init_wr)
        begin
            addr  = init_reg;
            we    = 1'b1;
            wdata = 8'h00;
        end
        else if (cmd.walk_rd || cmd.walk_wr)
        begin
            addr  = {PW'(wr_reg >> 3), CW'(wc_reg)};
            we    = cmd.walk_wr;
            wdata = wr_byte;
        end
        else
        begin
            addr  = {fpage_reg, CW'(fcol_reg)};
            we    = 1'b0;
            wdata = wr_byte;
        end
    end

    // pixel store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rd_reg <= mem[addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= '0;
            draw_row_reg  <= 9'd0;
            draw_col_reg  <= 9'd0;
            rows_left_reg <= 8'd0;
            d_inv_reg     <= 1'b0;
            d_h_reg       <= 8'd0;
            d_cf_reg      <= 8'd0;
            phase_reg     <= PH_IDLE;
            fpage_reg     <= '0;
            fpe_reg       <= '0;
            fcb_reg       <= 8'd0;
            fce_reg       <= 8'd0;
            fcol_reg      <= 8'd0;
            pword_reg     <= 8'd0;
        end
        else
        begin
            if (cmd.init_wr)
                init_reg <= init_reg + 1'b1;
            if (cmd.accept)
            begin
                draw_row_reg  <= draw_row_next;
                draw_col_reg  <= draw_col_next;
                rows_left_reg <= rows_left_next;
                d_inv_reg     <= d_inv_next;
                d_h_reg       <= d_h_next;
                d_cf_reg      <= d_cf_next;
                phase_reg     <= phase_next;
                fpage_reg     <= fpage_next;
                fpe_reg       <= fpe_next;
                fcb_reg       <= fcb_next;
                fce_reg       <= fce_next;
                fcol_reg      <= fcol_next;
                pword_reg     <= pword_next;
            end
        end
    end

    // walker and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            wr_reg       <= wr_next;
            wc_reg       <= wc_next;
            wr_end_reg   <= wr_end_next;
            wc_first_reg <= wc_first_next;
            wc_end_reg   <= wc_end_next;
            wk_reg       <= wk_next;
            wop_reg      <= wop_next;
            wval_reg     <= wval_next;
            wpat_reg     <= wpat_next;
            word_reg     <= res_word;
            isd_reg      <= res_isd;
            last_reg     <= res_last;
            st_reg       <= res_st;
        end
        else if (cmd.walk_wr)
        begin
            if (wc_reg == wc_end_reg)
            begin
                wc_reg <= wc_first_reg;
                wk_reg <= 3'd0;
                wr_reg <= wr_reg + 8'd1;
            end
            else
            begin
                wc_reg <= wc_reg + 8'd1;
                wk_reg <= wk_reg + 3'd1;
            end
        end
        if (cmd.fetch_load)
            word_reg <= rd_reg;
    end

    assign sts.init_done  = &init_reg;
    assign sts.walk_go    = walk_go;
    assign sts.fetch_need = fetch_need;
    assign sts.walk_last  = walk_last;

    assign word    = word_reg;
    assign is_data = isd_reg;
    assign last    = last_reg;
    assign status  = st_reg;

endmodule

FILE: rtl/mfpf_ctrl.sv
// controller state machine: store clearing, handshakes, walk and fetch sequencing
`include "monochrome_framebuffer_page_flush_defines.svh"
module mfpf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mfpf_pkg::ctrl_cmd_t cmd,
    input  mfpf_pkg::dp_sts_t   sts
);
    import mfpf_pkg::*;

    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_FETCH   = 3'd2;
    localparam logic [2:0] S_WALK_RD = 3'd3;
    localparam logic [2:0] S_WALK_WR = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       accept;

    // handshake
    assign s_tready = (state_reg == S_IDLE) && (!mvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    // commands to the datapath
    assign cmd.accept     = accept;
    assign cmd.init_wr    = (state_reg == S_INIT);
    assign cmd.walk_rd    = (state_reg == S_WALK_RD);
    assign cmd.walk_wr    = (state_reg == S_WALK_WR);
    assign cmd.fetch_load = (state_reg == S_FETCH);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
                if (sts.init_done)
                    state_next = S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    if (sts.fetch_need)
                        state_next = S_FETCH;
                    else if (sts.walk_go)
                        state_next = S_WALK_RD;
                end
            S_FETCH:
                state_next = S_IDLE;
            S_WALK_RD:
                state_next = S_WALK_WR;
            S_WALK_WR:
                state_next = sts.walk_last ? S_IDLE : S_WALK_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // output valid
    always_comb
    begin
        if ((accept && !sts.fetch_need) || (state_reg == S_FETCH))
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
        else
            mvalid_next = mvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    `MFPF_ASSERT_NXT(a_fetch_shows, clk, rst_n, state_reg == S_FETCH, mvalid_reg)
    `MFPF_ASSERT_NXT(a_walk_pair, clk, rst_n, state_reg == S_WALK_RD, state_reg == S_WALK_WR)
    `MFPF_ASSERT_NXT(a_fetch_entry, clk, rst_n, accept && sts.fetch_need, (state_reg == S_FETCH) && !mvalid_reg)

endmodule

FILE: rtl/monochrome_framebuffer_page_flush.sv
// top level of the page-mode monochrome framebuffer with flush sequencer
// result: registered when its transaction is accepted; a pulled data byte is first read from the store
// throughput: power, flush, plain draw, stray pixel and non-data pull 1 per cycle while m_tready is high
// a data pull holds off the next transaction until its byte is fetched, and pixel byte, toggle
// and clear until they have walked each pixel with a read and a write on the single memory port
// reset: the store is zeroed by a sweep over every address, during which no transaction is accepted
module monochrome_framebuffer_page_flush #(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // row_first, col_first, row_last, col_last, width, height,
                                  // pixel_byte, invert, toggle, fill, power_on, zero pad
    input  logic [2:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // word
    output logic [2:0]  m_tuser,  // is_data, status
    output logic        m_tlast
);
    import mfpf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_sts_t    sts;
    logic       is_data;
    logic [1:0] status;

    mfpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mfpf_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .command    (s_tuser),
        .row_first  (s_tdata[7:0]),
        .col_first  (s_tdata[15:8]),
        .row_last   (s_tdata[23:16]),
        .col_last   (s_tdata[31:24]),
        .width      (s_tdata[39:32]),
        .height     (s_tdata[47:40]),
        .pixel_byte (s_tdata[55:48]),
        .invert     (s_tdata[56]),
        .toggle     (s_tdata[57]),
        .fill       (s_tdata[58]),
        .power_on   (s_tdata[59]),
        .word       (m_tdata),
        .is_data    (is_data),
        .last       (m_tlast),
        .status     (status)
    );

    assign m_tuser = {status, is_data};

endmodule
